[sv/lbd_pkg.sv]
// shared types, codes and reset values for the ladder button debouncer
package lbd_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int THRESH_BITS     = 12;
    localparam int RUN_BITS        = 4;
    localparam int LADDER_BITS     = 2;
    localparam int EVENT_BITS      = 3;
    localparam int REG_IDX_BITS    = 3;

    // request kinds
    localparam logic OP_POLL    = 1'b0;
    localparam logic OP_CONSUME = 1'b1;

    // ladder button codes
    localparam logic [LADDER_BITS-1:0] LAD_NONE   = 2'd0;
    localparam logic [LADDER_BITS-1:0] LAD_TOP    = 2'd1;
    localparam logic [LADDER_BITS-1:0] LAD_MIDDLE = 2'd2;
    localparam logic [LADDER_BITS-1:0] LAD_BOTTOM = 2'd3;

    // event codes
    localparam logic [EVENT_BITS-1:0] EVT_NONE = 3'd0;
    localparam logic [EVENT_BITS-1:0] EVT_AUX  = 3'd4;

    // register indexes
    localparam logic [REG_IDX_BITS-1:0] REG_BOTTOM_HIGH  = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_MIDDLE_LOW   = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_MIDDLE_HIGH  = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_TOP_LOW      = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_TOP_HIGH     = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_IDLE_LOW     = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_STABLE_READS = 3'd6;

    // reset values
    localparam logic [THRESH_BITS-1:0] RST_BOTTOM_HIGH  = 12'd400;
    localparam logic [THRESH_BITS-1:0] RST_MIDDLE_LOW   = 12'd800;
    localparam logic [THRESH_BITS-1:0] RST_MIDDLE_HIGH  = 12'd1700;
    localparam logic [THRESH_BITS-1:0] RST_TOP_LOW      = 12'd1900;
    localparam logic [THRESH_BITS-1:0] RST_TOP_HIGH     = 12'd2800;
    localparam logic [THRESH_BITS-1:0] RST_IDLE_LOW     = 12'd3500;
    localparam logic [RUN_BITS-1:0]    RST_STABLE_READS = 4'd3;

    typedef struct packed {
        logic [THRESH_BITS-1:0] bottom_high;
        logic [THRESH_BITS-1:0] middle_low;
        logic [THRESH_BITS-1:0] middle_high;
        logic [THRESH_BITS-1:0] top_low;
        logic [THRESH_BITS-1:0] top_high;
        logic [THRESH_BITS-1:0] idle_low;
        logic [RUN_BITS-1:0]    stable_reads;
    } cfg_t;

endpackage

[sv/lbd_cfg_regs.sv]
// configuration register bank of the ladder button debouncer
module lbd_cfg_regs
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [lbd_pkg::REG_IDX_BITS-1:0]     wr_index,
    input  logic [lbd_pkg::THRESH_BITS-1:0]      wr_data,
    output lbd_pkg::cfg_t                        cfg
);

    lbd_pkg::cfg_t cfg_reg;
    lbd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                lbd_pkg::REG_BOTTOM_HIGH:  cfg_next.bottom_high  = wr_data;
                lbd_pkg::REG_MIDDLE_LOW:   cfg_next.middle_low   = wr_data;
                lbd_pkg::REG_MIDDLE_HIGH:  cfg_next.middle_high  = wr_data;
                lbd_pkg::REG_TOP_LOW:      cfg_next.top_low      = wr_data;
                lbd_pkg::REG_TOP_HIGH:     cfg_next.top_high     = wr_data;
                lbd_pkg::REG_IDLE_LOW:     cfg_next.idle_low     = wr_data;
                lbd_pkg::REG_STABLE_READS:
                    cfg_next.stable_reads = wr_data[lbd_pkg::RUN_BITS-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bottom_high  <= lbd_pkg::RST_BOTTOM_HIGH;
            cfg_reg.middle_low   <= lbd_pkg::RST_MIDDLE_LOW;
            cfg_reg.middle_high  <= lbd_pkg::RST_MIDDLE_HIGH;
            cfg_reg.top_low      <= lbd_pkg::RST_TOP_LOW;
            cfg_reg.top_high     <= lbd_pkg::RST_TOP_HIGH;
            cfg_reg.idle_low     <= lbd_pkg::RST_IDLE_LOW;
            cfg_reg.stable_reads <= lbd_pkg::RST_STABLE_READS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[sv/lbd_classify.sv]
// band classifier: maps a ladder sample to a button code
module lbd_classify #(
    parameter int SAMPLE_BITS = lbd_pkg::SAMPLE_BITS_DEF
)
(
    input  logic [SAMPLE_BITS-1:0]           sample,
    input  lbd_pkg::cfg_t                    cfg,
    input  logic [lbd_pkg::LADDER_BITS-1:0]  candidate,
    output logic [lbd_pkg::LADDER_BITS-1:0]  button
);

    localparam int CmpW = (SAMPLE_BITS > lbd_pkg::THRESH_BITS) ? SAMPLE_BITS
                                                              : lbd_pkg::THRESH_BITS;

    logic [CmpW-1:0] s_ext;
    logic [CmpW-1:0] bot_hi;
    logic [CmpW-1:0] mid_lo;
    logic [CmpW-1:0] mid_hi;
    logic [CmpW-1:0] top_lo;
    logic [CmpW-1:0] top_hi;
    logic [CmpW-1:0] idle_lo;

    assign s_ext   = CmpW'(sample);
    assign bot_hi  = CmpW'(cfg.bottom_high);
    assign mid_lo  = CmpW'(cfg.middle_low);
    assign mid_hi  = CmpW'(cfg.middle_high);
    assign top_lo  = CmpW'(cfg.top_low);
    assign top_hi  = CmpW'(cfg.top_high);
    assign idle_lo = CmpW'(cfg.idle_low);

    // first matching band wins; a gap keeps the current candidate
    always_comb
    begin
        if (s_ext <= bot_hi)
            button = lbd_pkg::LAD_BOTTOM;
        else if (s_ext >= mid_lo && s_ext <= mid_hi)
            button = lbd_pkg::LAD_MIDDLE;
        else if (s_ext >= top_lo && s_ext <= top_hi)
            button = lbd_pkg::LAD_TOP;
        else if (s_ext >= idle_lo)
            button = lbd_pkg::LAD_NONE;
        else
            button = candidate;
    end

endmodule

[sv/lbd_debounce.sv]
// debouncer: candidate, saturating run counter and committed state
module lbd_debounce #(
    parameter int W = lbd_pkg::LADDER_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          update,
    input  logic [W-1:0]                  seen,
    input  logic [lbd_pkg::RUN_BITS-1:0]  stable_reads,
    output logic [W-1:0]                  candidate,
    output logic [W-1:0]                  committed,
    output logic [W-1:0]                  committed_next,
    output logic                          commit
);

    logic [W-1:0]                 cand_reg;
    logic [W-1:0]                 cand_next;
    logic [lbd_pkg::RUN_BITS-1:0] run_reg;
    logic [lbd_pkg::RUN_BITS-1:0] run_next;
    logic [W-1:0]                 committed_reg;

    always_comb
    begin
        cand_next = cand_reg;
        run_next  = run_reg;
        if (seen == cand_reg)
        begin
            if (run_reg < stable_reads)
                run_next = run_reg + 1'b1;
        end
        else
        begin
            cand_next = seen;
            run_next  = lbd_pkg::RUN_BITS'(1);
        end
        commit         = (run_next >= stable_reads) && (committed_reg != cand_next);
        committed_next = commit ? cand_next : committed_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg      <= '0;
            run_reg       <= '0;
            committed_reg <= '0;
        end
        else if (update)
        begin
            cand_reg      <= cand_next;
            run_reg       <= run_next;
            committed_reg <= committed_next;
        end
    end

    assign candidate = cand_reg;
    assign committed = committed_reg;

endmodule

[sv/ladder_button_debouncer_core.sv]
// top level of the ladder button debouncer
// Decodes a resistor-ladder button set and one active-low pin button.
// Slave stream: one request per beat; s_tuser selects poll (0) or consume
// (1); on a poll s_tdata carries the ladder ADC sample and the pin level.
// Master stream: one result per request, in request order, carrying the
// consumed event code (zero on a poll), the committed ladder button and
// the committed pin button state.
// cfg channel writes one band or debounce register per beat; cfg_ready is
// always high. Write it only while no request is in flight.
// An accepted request passes the input register, then the result register,
// before m_tvalid rises; a stall can hold it in the input register.
// Throughput: one request per cycle while m_tready does not stall the
// result register; the debouncer update is a single compare/increment
// step between the two registers.
// When the receiver stalls, the result register holds and the input
// register takes one more request; after that s_tready drops.
// Reset clears the debouncers, the pending event and both valid flags, and
// loads the registers with their default bands and a read count of three.
module ladder_button_debouncer_core #(
    parameter int  SAMPLE_BITS = lbd_pkg::SAMPLE_BITS_DEF,
    localparam int InDataW     = ((SAMPLE_BITS + 1 + 7) / 8) * 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [InDataW-1:0]                 s_tdata,   // ladder_sample, pin_level
    input  logic                               s_tuser,   // op
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // event_taken, ladder_state, aux_pressed
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lbd_pkg::REG_IDX_BITS-1:0]   cfg_index,
    input  logic [lbd_pkg::THRESH_BITS-1:0]    cfg_data
);

    lbd_pkg::cfg_t cfg;

    logic                   in_valid_reg;
    logic                   in_op_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic                   in_pin_reg;

    logic                               out_valid_reg;
    logic [lbd_pkg::EVENT_BITS-1:0]     out_event_reg;
    logic [lbd_pkg::LADDER_BITS-1:0]    out_ladder_reg;
    logic                               out_aux_reg;

    logic [lbd_pkg::EVENT_BITS-1:0]     pending_reg;
    logic [lbd_pkg::EVENT_BITS-1:0]     pending_next;

    logic                               advance;
    logic                               poll_upd;
    logic                               in_take;

    logic [lbd_pkg::LADDER_BITS-1:0]    lad_seen;
    logic [lbd_pkg::LADDER_BITS-1:0]    lad_cand;
    logic [lbd_pkg::LADDER_BITS-1:0]    lad_committed;
    logic [lbd_pkg::LADDER_BITS-1:0]    lad_committed_next;
    logic                               lad_commit;

    logic                               aux_seen;
    logic                               aux_cand;
    logic                               aux_committed;
    logic                               aux_committed_next;
    logic                               aux_commit;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_take   = s_tvalid && s_tready;
    assign poll_upd  = advance && (in_op_reg == lbd_pkg::OP_POLL);
    assign aux_seen  = ~in_pin_reg;

    lbd_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    lbd_classify #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_classify
    (
        .sample    (in_sample_reg),
        .cfg       (cfg),
        .candidate (lad_cand),
        .button    (lad_seen)
    );

    lbd_debounce #(
        .W (lbd_pkg::LADDER_BITS)
    ) u_lad_deb
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .update         (poll_upd),
        .seen           (lad_seen),
        .stable_reads   (cfg.stable_reads),
        .candidate      (lad_cand),
        .committed      (lad_committed),
        .committed_next (lad_committed_next),
        .commit         (lad_commit)
    );

    lbd_debounce #(
        .W (1)
    ) u_aux_deb
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .update         (poll_upd),
        .seen           (aux_seen),
        .stable_reads   (cfg.stable_reads),
        .candidate      (aux_cand),
        .committed      (aux_committed),
        .committed_next (aux_committed_next),
        .commit         (aux_commit)
    );

    // pin press is handled after the ladder, so it wins the pending slot
    always_comb
    begin
        pending_next = pending_reg;
        if (advance)
        begin
            if (in_op_reg == lbd_pkg::OP_CONSUME)
                pending_next = lbd_pkg::EVT_NONE;
            else
            begin
                if (lad_commit && (lad_committed_next != lbd_pkg::LAD_NONE))
                    pending_next = lbd_pkg::EVENT_BITS'(lad_committed_next);
                if (aux_commit && aux_committed_next)
                    pending_next = lbd_pkg::EVT_AUX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pending_reg   <= lbd_pkg::EVT_NONE;
        end
        else
        begin
            pending_reg <= pending_next;
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg     <= s_tuser;
            in_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
            in_pin_reg    <= s_tdata[SAMPLE_BITS];
        end
        if (advance)
        begin
            if (in_op_reg == lbd_pkg::OP_CONSUME)
            begin
                out_event_reg  <= pending_reg;
                out_ladder_reg <= lad_committed;
                out_aux_reg    <= aux_committed;
            end
            else
            begin
                out_event_reg  <= lbd_pkg::EVT_NONE;
                out_ladder_reg <= lad_committed_next;
                out_aux_reg    <= aux_committed_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_aux_reg, out_ladder_reg, out_event_reg};

    // a consume request always leaves the pending slot empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_op_reg == lbd_pkg::OP_CONSUME) |=> (pending_reg == lbd_pkg::EVT_NONE))
        else $error("pending event not cleared by consume");

    // a committed pin press takes the pending slot even over a ladder press
    assert property (@(posedge clk) disable iff (!rst_n)
        (poll_upd && aux_commit && aux_committed_next) |=> (pending_reg == lbd_pkg::EVT_AUX))
        else $error("pin press not latched as pending event");

    // the input register is free to take a request whenever it is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    // a result never carries an event code beyond the pin button
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_event_reg <= lbd_pkg::EVT_AUX))
        else $error("invalid event code on result");

endmodule
